>>> design/qcv_pkg.sv
// Shared types and constants for the quadrature counter with speed estimate.
`default_nettype none

package qcv_pkg;

  localparam int CFG_W   = 16;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 32;
  localparam int SPEED_W = 48;
  localparam int DIV_W   = CFG_W + TIME_W;
  localparam int CH_W    = 16;

  // round(2*pi * 1e6 * 2^25)
  localparam logic [63:0] ANGLE_K25 = 64'd210828714133157;

  localparam logic [CFG_W-1:0] PPR_RESET  = 16'd1024;
  localparam logic [CFG_W-1:0] MIN_RESET  = 16'd1000;
  localparam logic [CFG_W-1:0] GAIN_RESET = 16'd19661;

  localparam logic [1:0] CFG_PPR          = 2'd0;
  localparam logic [1:0] CFG_MIN_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_FILTER_GAIN  = 2'd2;

  typedef enum logic [1:0] {
    REQ_EDGE_A = 2'd0,
    REQ_EDGE_B = 2'd1,
    REQ_SPEED  = 2'd2,
    REQ_RESET  = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              level_a;
    logic              level_b;
    logic [TIME_W-1:0] now_us;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   position_count;
    logic signed [SPEED_W-1:0] speed;
    logic                      speed_valid;
  } out_t;

  typedef struct packed {
    logic latch;
    logic prep;
    logic mul_step;
    logic div_step;
    logic filt1;
    logic filt2;
    logic filt3;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic speed_go;
    logic cnt_zero;
  } status_t;

endpackage

`default_nettype wire

>>> design/qcv_dp.sv
// Datapath: config registers, counter state, multiply, divider and speed filter.
`default_nettype none

module qcv_dp #(
  parameter int COUNT_BITS      = 32,
  parameter int SPEED_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [qcv_pkg::CFG_W-1:0]   cfg_data,
  input  qcv_pkg::in_t                in_data,
  input  qcv_pkg::cmd_t               cmd,
  output qcv_pkg::status_t            st,
  output qcv_pkg::out_t               out_data
);
  import qcv_pkg::*;

  localparam int K_W     = SPEED_FRAC_BITS + 23;
  localparam int NCH     = (K_W + CH_W - 1) / CH_W;
  localparam int CI_W    = $clog2(NCH);
  localparam int P_W     = COUNT_BITS + K_W;
  localparam int DIV_CYC = (P_W + 1) / 2;
  localparam int DW      = 2 * DIV_CYC;
  localparam int CNT_W   = $clog2(DIV_CYC);
  localparam int Q_W     = SPEED_W + 1;
  localparam int PR_W    = 66;
  localparam logic [63:0] K_VAL =
    ((ANGLE_K25 >> (24 - SPEED_FRAC_BITS)) + 64'd1) >> 1;
  localparam logic [NCH*CH_W-1:0] K_PAD = K_VAL[NCH*CH_W-1:0];
  localparam logic [SPEED_W-1:0] LIM_POS = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic [SPEED_W-1:0] LIM_NEG = {1'b1, {(SPEED_W-1){1'b0}}};

  logic [CFG_W-1:0]          ppr;
  logic [CFG_W-1:0]          min_iv;
  logic [CFG_W-1:0]          gain;
  in_t                       item;
  logic [COUNT_BITS-1:0]     count;
  logic [COUNT_BITS-1:0]     count_last;
  logic [TIME_W-1:0]         time_last;
  logic signed [SPEED_W-1:0] filt;
  logic                      neg;
  logic [COUNT_BITS-1:0]     mag;
  logic [DIV_W-1:0]          div_r;
  logic [DW-1:0]             acc;
  logic [DIV_W-1:0]          rem;
  logic [Q_W-1:0]            q;
  logic                      over;
  logic [CNT_W-1:0]          cnt;
  logic signed [SPEED_W-1:0] omega;
  logic signed [PR_W-1:0]    p1;
  logic signed [PR_W-1:0]    p2;
  logic [SPEED_W-1:0]        res_speed;
  logic                      res_valid;

  logic [CH_W-1:0]            k_chunk [NCH];
  logic [TIME_W-1:0]          dt;
  logic                       speed_ok;
  logic [COUNT_BITS-1:0]      dc;
  logic [COUNT_BITS+CH_W-1:0] pp;
  logic [DIV_W:0]             s1;
  logic [DIV_W:0]             s2;
  logic                       sat;
  logic [SPEED_W-1:0]         lim;
  logic [SPEED_W-1:0]         qm;
  logic [CFG_W:0]             g_comp;
  logic signed [PR_W-1:0]     s_sum;
  logic [POS_W-1:0]           pos;
  logic                       up_a;
  logic                       up_b;

  for (genvar i = 0; i < NCH; i++) begin : g_kchunk
    assign k_chunk[i] = K_PAD[i*CH_W +: CH_W];
  end

  if (COUNT_BITS >= POS_W) begin : g_pos_trunc
    assign pos = count[POS_W-1:0];
  end else begin : g_pos_sext
    assign pos = {{(POS_W-COUNT_BITS){count[COUNT_BITS-1]}}, count};
  end

  // one restoring division bit: {new remainder, quotient bit}
  function automatic logic [DIV_W:0] div_bit(input logic [DIV_W-1:0] r,
                                             input logic             b,
                                             input logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    t    = {r, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[DIV_W-1:0], 1'b1};
    end
    return {t[DIV_W-1:0], 1'b0};
  endfunction

  always_comb begin
    dt       = item.now_us - time_last;
    speed_ok = (dt != '0) && (dt >= {{(TIME_W-CFG_W){1'b0}}, min_iv}) && (ppr != '0);
    st.speed_go = (item.req_type == REQ_SPEED) && speed_ok;
    st.cnt_zero = (cnt == '0);
    dc     = count - count_last;
    up_a   = (item.level_a == item.level_b);
    up_b   = (item.level_a != item.level_b);
    pp     = mag * k_chunk[cnt[CI_W-1:0]];
    s1     = div_bit(rem, acc[DW-1], div_r);
    s2     = div_bit(s1[DIV_W:1], acc[DW-2], div_r);
    lim    = neg ? LIM_NEG : LIM_POS;
    sat    = over || (q > {1'b0, lim});
    qm     = sat ? lim : q[SPEED_W-1:0];
    g_comp = {1'b1, {CFG_W{1'b0}}} - {1'b0, gain};
    s_sum  = p1 + p2 + PR_W'(32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ppr    <= PPR_RESET;
      min_iv <= MIN_RESET;
      gain   <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PPR:          ppr    <= cfg_data;
        CFG_MIN_INTERVAL: min_iv <= cfg_data;
        CFG_FILTER_GAIN:  gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      count_last <= '0;
      time_last  <= '0;
      filt       <= '0;
    end else begin
      if (cmd.prep) begin
        unique case (req_t'(item.req_type))
          REQ_EDGE_A: count <= up_a ? count + COUNT_BITS'(1) : count - COUNT_BITS'(1);
          REQ_EDGE_B: count <= up_b ? count + COUNT_BITS'(1) : count - COUNT_BITS'(1);
          REQ_RESET: begin
            count      <= '0;
            count_last <= '0;
            time_last  <= item.now_us;
          end
          REQ_SPEED: ;
        endcase
      end
      if (cmd.filt3) begin
        filt       <= s_sum[SPEED_W+15:16];
        count_last <= count;
        time_last  <= item.now_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= in_data;
    end
    if (cmd.prep) begin
      neg       <= dc[COUNT_BITS-1];
      mag       <= dc[COUNT_BITS-1] ? (~dc + COUNT_BITS'(1)) : dc;
      div_r     <= ppr * dt;
      acc       <= '0;
      rem       <= '0;
      q         <= '0;
      over      <= 1'b0;
      cnt       <= CNT_W'(NCH - 1);
      res_speed <= '0;
      res_valid <= 1'b0;
    end
    if (cmd.mul_step) begin
      acc <= {acc[DW-CH_W-1:0], {CH_W{1'b0}}}
             + {{(DW-COUNT_BITS-CH_W){1'b0}}, pp};
      cnt <= (cnt == '0) ? CNT_W'(DIV_CYC - 1) : cnt - CNT_W'(1);
    end
    if (cmd.div_step) begin
      acc  <= {acc[DW-3:0], 2'b00};
      rem  <= s2[DIV_W:1];
      q    <= {q[Q_W-3:0], s1[0], s2[0]};
      over <= over | q[Q_W-1] | q[Q_W-2];
      cnt  <= cnt - CNT_W'(1);
    end
    if (cmd.filt1) begin
      omega <= neg ? $signed(~qm + SPEED_W'(1)) : $signed(qm);
      p1    <= $signed({{(PR_W-CFG_W-1){1'b0}}, g_comp})
               * $signed({{(PR_W-SPEED_W){filt[SPEED_W-1]}}, filt});
    end
    if (cmd.filt2) begin
      p2 <= $signed({{(PR_W-CFG_W){1'b0}}, gain})
            * $signed({{(PR_W-SPEED_W){omega[SPEED_W-1]}}, omega});
    end
    if (cmd.filt3) begin
      res_speed <= s_sum[SPEED_W+15:16];
      res_valid <= 1'b1;
    end
    if (cmd.emit) begin
      out_data.position_count <= pos;
      out_data.speed          <= res_speed;
      out_data.speed_valid    <= res_valid;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> div_r != '0)
    else $error("division step with zero divisor");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem < div_r)
    else $error("partial remainder not below divisor");

  a_reset_req: assert property (@(posedge clk) disable iff (rst)
    (cmd.prep && item.req_type == REQ_RESET) |=> (count == '0 && count_last == '0))
    else $error("reset request did not clear count history");

endmodule

`default_nettype wire

>>> design/qcv_ctrl.sv
// Controller: sequences prep, multiply, divide, filter and result transfer.
`default_nettype none

module qcv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  qcv_pkg::status_t st,
  output qcv_pkg::cmd_t    cmd
);
  import qcv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FILT1,
    S_FILT2,
    S_FILT3,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd          = '0;
    cmd.latch    = (state == S_IDLE) && in_valid;
    cmd.prep     = (state == S_PREP);
    cmd.mul_step = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.filt1    = (state == S_FILT1);
    cmd.filt2    = (state == S_FILT2);
    cmd.filt3    = (state == S_FILT3);
    cmd.emit     = (state == S_EMIT) && (!out_valid || out_ready);
    state_next   = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_PREP;
      S_PREP:  state_next = st.speed_go ? S_MUL : S_EMIT;
      S_MUL:   if (st.cnt_zero) state_next = S_DIV;
      S_DIV:   if (st.cnt_zero) state_next = S_FILT1;
      S_FILT1: state_next = S_FILT2;
      S_FILT2: state_next = S_FILT3;
      S_FILT3: state_next = S_EMIT;
      S_EMIT:  if (cmd.emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cmd_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  a_latch_prep: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> cmd.prep)
    else $error("accepted item not prepared next cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.emit)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> design/quadrature_count_velocity.sv
// Top level: x4 quadrature counter with filtered angular speed estimate.
// Edge, reset and speed items with too short an interval or zero PPR go from latch and prep
// straight to the output register; other speed items first run the chunked multiply, the
//   2-bit-per-cycle restoring divider and the filter steps.
// One item in flight; the output register lets a new item enter while a result waits.
// Sync reset clears count, count history, last time and filter; config returns to defaults.
`default_nettype none

module quadrature_count_velocity #(
  parameter int COUNT_BITS      = 32,
  parameter int SPEED_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [qcv_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  qcv_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output qcv_pkg::out_t             out_data
);
  import qcv_pkg::*;

  cmd_t    cmd;
  status_t st;

  qcv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  qcv_dp #(
    .COUNT_BITS      (COUNT_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
